[hdl/i2cls_pkg.sv]
// shared types and constants for the light sensor read master
`timescale 1ns / 1ps

package i2cls_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_WR_ADDR   = 3'd0;
    localparam logic [2:0] CFG_PWR_CMD   = 3'd1;
    localparam logic [2:0] CFG_MODE_CMD  = 3'd2;
    localparam logic [2:0] CFG_UNIT_TKS  = 3'd3;
    localparam logic [2:0] CFG_SETTLE    = 3'd4;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // raw * 5 / 6 as a multiply by ceil(5 * 2^18 / 6), exact for any 16-bit raw
    localparam int unsigned  LUX_SHIFT = 18;
    localparam logic [17:0]  LUX_MUL   = 18'd218454;

    typedef struct packed {
        logic kind;
        logic sda_in;
    } t_in;

    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        sda_drive;
        logic        busy_res;
        logic        done_res;
        logic [15:0] raw_value;
        logic [15:0] lux_value;
        logic        ack_missing;
    } t_out;

    typedef struct packed {
        logic [7:0]  write_address_byte;
        logic [7:0]  power_on_command;
        logic [7:0]  mode_command;
        logic [15:0] delay_unit_ticks;
        logic [15:0] settle_units;
    } t_cfg;

endpackage

[hdl/i2c_light_sensor_read_master_top.sv]
// light sensor read master: config registers, sequencer and output register
// a word's result is written into the output register as the word is accepted
// throughput: one word per cycle while the output register is not stalled
// the output register takes a new result in the cycle its old one is taken
// reset (i_rst_n low, synchronous): sequencer idle, counters and result cleared,
// config back to write address 70, power-on 1, mode 16, 50 ticks a unit, 200 settle units
`timescale 1ns / 1ps

module i2c_light_sensor_read_master_top
    import i2cls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_out w_res;
    t_out r_out_data;
    logic r_out_valid;
    logic w_step;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_step     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_address_byte <= 8'd70;
            r_cfg.power_on_command   <= 8'd1;
            r_cfg.mode_command       <= 8'd16;
            r_cfg.delay_unit_ticks   <= 16'd50;
            r_cfg.settle_units       <= 16'd200;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WR_ADDR:  r_cfg.write_address_byte <= i_cfg_data[7:0];
                CFG_PWR_CMD:  r_cfg.power_on_command   <= i_cfg_data[7:0];
                CFG_MODE_CMD: r_cfg.mode_command       <= i_cfg_data[7:0];
                CFG_UNIT_TKS: r_cfg.delay_unit_ticks   <= i_cfg_data;
                CFG_SETTLE:   r_cfg.settle_units       <= i_cfg_data;
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    i2cls_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_in    (i_in_data),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hdl/i2cls_lux.sv]
// raw count to lux conversion, raw / 1.2 truncated
`timescale 1ns / 1ps

module i2cls_lux
    import i2cls_pkg::*;
(
    input  logic [15:0] i_raw,
    output logic [15:0] o_lux
);

    logic [33:0] w_prod;

    assign w_prod = {18'd0, i_raw} * {16'd0, LUX_MUL};
    assign o_lux  = w_prod[LUX_SHIFT +: 16];

endmodule

[hdl/i2cls_core.sv]
// sequencer state, per-word next state and line levels
`timescale 1ns / 1ps

module i2cls_core
    import i2cls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  t_in  i_in,
    input  t_cfg i_cfg,
    output t_out o_res
);

    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_START_A   = 5'd1;
    localparam logic [4:0] PH_START_B   = 5'd2;
    localparam logic [4:0] PH_TX_SET    = 5'd3;
    localparam logic [4:0] PH_TX_HIGH   = 5'd4;
    localparam logic [4:0] PH_TX_LOW    = 5'd5;
    localparam logic [4:0] PH_ACK_HIGH  = 5'd6;
    localparam logic [4:0] PH_ACK_HOLD  = 5'd7;
    localparam logic [4:0] PH_STOP_A    = 5'd8;
    localparam logic [4:0] PH_STOP_B    = 5'd9;
    localparam logic [4:0] PH_STOP_C    = 5'd10;
    localparam logic [4:0] PH_SETTLE    = 5'd11;
    localparam logic [4:0] PH_RX_HIGH   = 5'd12;
    localparam logic [4:0] PH_RX_HOLD   = 5'd13;
    localparam logic [4:0] PH_RX_LOW    = 5'd14;
    localparam logic [4:0] PH_MACK_SET  = 5'd15;
    localparam logic [4:0] PH_MACK_HIGH = 5'd16;

    // byte slots: 0 addr, 1 power-on, 2 addr, 3 mode, 4 read addr, 5 high, 6 low
    localparam logic [2:0] SL_ADDR_1  = 3'd0;
    localparam logic [2:0] SL_PWR     = 3'd1;
    localparam logic [2:0] SL_ADDR_2  = 3'd2;
    localparam logic [2:0] SL_MODE    = 3'd3;
    localparam logic [2:0] SL_RD_ADDR = 3'd4;
    localparam logic [2:0] SL_RX_HIGH = 3'd5;
    localparam logic [2:0] SL_RX_LOW  = 3'd6;

    logic [4:0]  r_phase,    n_phase;
    logic [2:0]  r_bit_cnt,  n_bit_cnt;
    logic [15:0] r_unit_cnt, n_unit_cnt;
    logic [15:0] r_settle,   n_settle;
    logic [7:0]  r_shift,    n_shift;
    logic [7:0]  r_high,     n_high;
    logic [15:0] r_raw,      n_raw;
    logic [15:0] r_lux,      n_lux;
    logic        r_ack,      n_ack;
    logic [2:0]  r_slot,     n_slot;
    logic        n_done;

    logic [15:0] w_unit_inc;
    logic [15:0] w_unit_lim;
    logic [15:0] w_settle_inc;
    logic [15:0] w_lux;
    logic [7:0]  w_tx_byte;
    logic        w_tx_bit;
    logic        w_mack_bit;
    logic        w_scl, w_sda, w_drv;

    // the completing stop latches {high, shift}, so convert that straight from the registers
    i2cls_lux u_lux (
        .i_raw ({r_high, r_shift}),
        .o_lux (w_lux)
    );

    assign w_unit_inc   = r_unit_cnt + 16'd1;
    assign w_unit_lim   = (i_cfg.delay_unit_ticks == 16'd0) ? 16'd1 : i_cfg.delay_unit_ticks;
    assign w_settle_inc = r_settle + 16'd1;

    always_comb begin
        n_phase    = r_phase;
        n_bit_cnt  = r_bit_cnt;
        n_unit_cnt = r_unit_cnt;
        n_settle   = r_settle;
        n_shift    = r_shift;
        n_high     = r_high;
        n_raw      = r_raw;
        n_lux      = r_lux;
        n_ack      = r_ack;
        n_slot     = r_slot;
        n_done     = 1'b0;
        if (i_in.kind) begin
            if (r_phase == PH_IDLE) begin
                n_phase    = PH_START_A;
                n_slot     = SL_ADDR_1;
                n_bit_cnt  = 3'd0;
                n_unit_cnt = 16'd0;
                n_settle   = 16'd0;
                n_shift    = 8'd0;
                n_ack      = 1'b0;
            end
        end else if (r_phase != PH_IDLE) begin
            n_unit_cnt = w_unit_inc;
            if (w_unit_inc >= w_unit_lim) begin
                n_unit_cnt = 16'd0;
                unique case (r_phase)
                    PH_START_A: n_phase = PH_START_B;
                    PH_START_B: begin
                        n_phase   = PH_TX_SET;
                        n_bit_cnt = 3'd0;
                    end
                    PH_TX_SET:  n_phase = PH_TX_HIGH;
                    PH_TX_HIGH: n_phase = PH_TX_LOW;
                    PH_TX_LOW: begin
                        if (r_bit_cnt != 3'd7) begin
                            n_bit_cnt = r_bit_cnt + 3'd1;
                            n_phase   = PH_TX_SET;
                        end else begin
                            n_phase = PH_ACK_HIGH;
                        end
                    end
                    PH_ACK_HIGH: begin
                        if (i_in.sda_in) begin
                            n_ack = 1'b1;
                        end
                        n_phase = PH_ACK_HOLD;
                    end
                    PH_ACK_HOLD: begin
                        n_bit_cnt = 3'd0;
                        if (r_slot == SL_ADDR_1 || r_slot == SL_ADDR_2) begin
                            n_slot  = r_slot + 3'd1;
                            n_phase = PH_TX_SET;
                        end else if (r_slot == SL_RD_ADDR) begin
                            n_slot  = SL_RX_HIGH;
                            n_shift = 8'd0;
                            n_phase = PH_RX_HIGH;
                        end else begin
                            n_phase = PH_STOP_A;
                        end
                    end
                    PH_STOP_A: n_phase = PH_STOP_B;
                    PH_STOP_B: n_phase = PH_STOP_C;
                    PH_STOP_C: begin
                        if (r_slot == SL_PWR) begin
                            n_slot  = SL_ADDR_2;
                            n_phase = PH_START_A;
                        end else if (r_slot == SL_MODE) begin
                            n_slot   = SL_RD_ADDR;
                            n_settle = 16'd0;
                            n_phase  = (i_cfg.settle_units == 16'd0) ? PH_START_A : PH_SETTLE;
                        end else begin
                            n_raw   = {r_high, r_shift};
                            n_lux   = w_lux;
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end
                    end
                    PH_SETTLE: begin
                        n_settle = w_settle_inc;
                        if (w_settle_inc >= i_cfg.settle_units) begin
                            n_phase = PH_START_A;
                        end
                    end
                    PH_RX_HIGH: begin
                        n_shift = {r_shift[6:0], i_in.sda_in};
                        n_phase = PH_RX_HOLD;
                    end
                    PH_RX_HOLD: n_phase = PH_RX_LOW;
                    PH_RX_LOW: begin
                        if (r_bit_cnt != 3'd7) begin
                            n_bit_cnt = r_bit_cnt + 3'd1;
                            n_phase   = PH_RX_HIGH;
                        end else begin
                            if (r_slot == SL_RX_HIGH) begin
                                n_high = r_shift;
                            end
                            n_phase = PH_MACK_SET;
                        end
                    end
                    PH_MACK_SET: n_phase = PH_MACK_HIGH;
                    PH_MACK_HIGH: begin
                        if (r_slot == SL_RX_HIGH) begin
                            n_slot    = SL_RX_LOW;
                            n_bit_cnt = 3'd0;
                            n_shift   = 8'd0;
                            n_phase   = PH_RX_HIGH;
                        end else begin
                            n_phase = PH_STOP_A;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // byte being sent in the upcoming slot
    always_comb begin
        case (n_slot)
            SL_PWR:     w_tx_byte = i_cfg.power_on_command;
            SL_MODE:    w_tx_byte = i_cfg.mode_command;
            SL_RD_ADDR: w_tx_byte = i_cfg.write_address_byte + 8'd1;
            default:    w_tx_byte = i_cfg.write_address_byte;
        endcase
    end

    // msb first
    assign w_tx_bit   = w_tx_byte[~n_bit_cnt];
    // ack after the high byte, nack after the low byte
    assign w_mack_bit = (n_slot == SL_RX_HIGH) ? 1'b0 : 1'b1;

    always_comb begin
        w_scl = 1'b1;
        w_sda = 1'b1;
        w_drv = 1'b1;
        unique case (n_phase) inside
            PH_START_B: w_sda = 1'b0;
            PH_TX_SET, PH_TX_LOW: begin
                w_scl = 1'b0;
                w_sda = w_tx_bit;
            end
            PH_TX_HIGH: w_sda = w_tx_bit;
            PH_ACK_HIGH, PH_ACK_HOLD, PH_RX_HIGH, PH_RX_HOLD: w_drv = 1'b0;
            PH_RX_LOW: begin
                w_scl = 1'b0;
                w_drv = 1'b0;
            end
            PH_STOP_A: begin
                w_scl = 1'b0;
                w_sda = 1'b0;
            end
            PH_STOP_B: w_sda = 1'b0;
            PH_MACK_SET: begin
                w_scl = 1'b0;
                w_sda = w_mack_bit;
            end
            PH_MACK_HIGH: w_sda = w_mack_bit;
            PH_START_A, PH_STOP_C, PH_SETTLE: w_drv = 1'b1;
            default: w_drv = 1'b0;
        endcase
    end

    always_comb begin
        o_res.scl_level   = w_scl;
        o_res.sda_level   = w_sda;
        o_res.sda_drive   = w_drv;
        o_res.busy_res    = (n_phase != PH_IDLE);
        o_res.done_res    = n_done;
        o_res.raw_value   = n_raw;
        o_res.lux_value   = n_lux;
        o_res.ack_missing = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bit_cnt  <= 3'd0;
            r_unit_cnt <= 16'd0;
            r_settle   <= 16'd0;
            r_shift    <= 8'd0;
            r_high     <= 8'd0;
            r_raw      <= 16'd0;
            r_lux      <= 16'd0;
            r_ack      <= 1'b0;
            r_slot     <= SL_ADDR_1;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_bit_cnt  <= n_bit_cnt;
            r_unit_cnt <= n_unit_cnt;
            r_settle   <= n_settle;
            r_shift    <= n_shift;
            r_high     <= n_high;
            r_raw      <= n_raw;
            r_lux      <= n_lux;
            r_ack      <= n_ack;
            r_slot     <= n_slot;
        end
    end

endmodule

[hdl/i2cls_chk.sv]
// port-level checks for the light sensor read master
`timescale 1ns / 1ps

module i2cls_chk
    import i2cls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic o_in_ready,
    input  logic o_out_valid,
    input  logic i_out_ready,
    input  t_out o_out_data
);

    logic [18:0] w_raw5;
    logic [18:0] w_lux6;

    assign w_raw5 = {3'd0, o_out_data.raw_value} * 19'd5;
    assign w_lux6 = {3'd0, o_out_data.lux_value} * 19'd6;

    // a stalled word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    // every accepted word shows up on the output next cycle
    a_accept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted word produced no result");

    // the finishing word already shows the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res)
        else $error("done flagged while still busy");

    // lux is raw * 5 / 6 truncated
    a_lux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (w_lux6 <= w_raw5) && (w_raw5 < w_lux6 + 19'd6))
        else $error("lux does not match raw");

    // bus is released while idle
    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.busy_res |->
            o_out_data.scl_level && o_out_data.sda_level && !o_out_data.sda_drive)
        else $error("bus not released while idle");

endmodule

bind i2c_light_sensor_read_master_top i2cls_chk u_i2cls_chk (.*);
